/* src/dragged_span_edge_snap_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dragged span edge snapper
// Shared helpers for concurrent checks in the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef DRAGGED_SPAN_EDGE_SNAP_CORE_DEFINES_SVH
`define DRAGGED_SPAN_EDGE_SNAP_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DSES_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dses: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DSES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dses: next-cycle check failed");

`endif

/* src/dses_pkg.sv */
// ----------------------------------------------------------------------------
// dses_pkg
// Types and constants shared by the dragged span edge snapper modules.
// ----------------------------------------------------------------------------
package dses_pkg;

  localparam int FRAME_BITS  = 48;
  localparam int DUR_BITS    = 47;
  localparam int RADIUS_BITS = 16;
  localparam int DIST_BITS   = FRAME_BITS + 1;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] EDGE_NONE  = 2'd0;
  localparam logic [1:0] EDGE_LEAD  = 2'd1;
  localparam logic [1:0] EDGE_TRAIL = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Sign bit of a frame; flipping it maps signed order onto unsigned order.
  localparam logic [FRAME_BITS-1:0] KEY_SIGN = {1'b1, {(FRAME_BITS-1){1'b0}}};

  typedef struct packed {
    logic [1:0]                   opcode;
    logic signed [FRAME_BITS-1:0] target_frame;
    logic signed [FRAME_BITS-1:0] raw_start;
    logic [DUR_BITS-1:0]          duration;
  } dses_in_t;

  typedef struct packed {
    logic signed [FRAME_BITS-1:0] start_frame;
    logic [1:0]                   edge_used;
    logic                         status;
  } dses_out_t;

  typedef struct packed {
    logic capture;
    logic load_exec;
    logic clear_tab;
    logic res_zero;
    logic setup;
    logic res_raw;
    logic scan_issue;
    logic fin1;
    logic fin2;
    logic fin3;
    logic out_load;
  } dses_cmd_t;

  typedef struct packed {
    logic snap_off;
    logic scan_done;
    logic pipe_busy;
  } dses_stat_t;

endpackage

/* src/dses_ctrl.sv */
// ----------------------------------------------------------------------------
// dses_ctrl
// Sequencer for load, clear and query transactions and the output slot.
// ----------------------------------------------------------------------------
`include "dragged_span_edge_snap_core_defines.svh"

module dses_ctrl import dses_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_opcode_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dses_stat_t stat_i,
  output dses_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_DRAIN = 4'd5;
  localparam logic [3:0] S_FIN1  = 4'd6;
  localparam logic [3:0] S_FIN2  = 4'd7;
  localparam logic [3:0] S_FIN3  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (in_opcode_i)
            OP_LOAD:  state_d = S_LOAD;
            OP_QUERY: state_d = S_SETUP;
            default:  state_d = S_CLEAR;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load_exec = 1'b1;
        state_d         = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.clear_tab = 1'b1;
        cmd_o.res_zero  = 1'b1;
        state_d         = S_DONE;
      end
      S_SETUP: begin
        if (stat_i.snap_off) begin
          cmd_o.res_raw = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.setup = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.scan_issue = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = S_FIN1;
        end
      end
      S_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.fin2 = 1'b1;
        state_d    = S_FIN3;
      end
      S_FIN3: begin
        cmd_o.fin3 = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `DSES_ASSERT_NEXT(a_accept_blocks, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `DSES_ASSERT_IMPL(a_out_slot_free, clk_i, rst_ni, cmd_o.out_load, !out_valid_q || out_ready_i)
  `DSES_ASSERT_IMPL(a_fin_pipe_empty, clk_i, rst_ni, cmd_o.fin1, !stat_i.pipe_busy)

endmodule

/* src/dses_dpath.sv */
// ----------------------------------------------------------------------------
// dses_dpath
// Target table, scan pipeline, nearest-target trackers and result registers.
// ----------------------------------------------------------------------------
`include "dragged_span_edge_snap_core_defines.svh"

module dses_dpath import dses_pkg::*; #(
  parameter int MAX_TARGETS = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dses_in_t               in_data_i,
  input  logic                   cfg_we_i,
  input  logic [RADIUS_BITS-1:0] cfg_wdata_i,
  input  dses_cmd_t              cmd_i,
  output dses_stat_t             stat_o,
  output dses_out_t              out_data_o
);

  localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W = $clog2(MAX_TARGETS + 1);
  localparam int FB    = FRAME_BITS;
  localparam int DB    = DIST_BITS;

  typedef struct packed {
    logic          moved;
    logic [FB-1:0] tgt;
    logic [DB-1:0] gap;
  } pick_t;

  // Decide one edge from its nearest targets at-or-after and before it.
  function automatic pick_t pick_edge(input logic ff, input logic [FB-1:0] fk,
                                      input logic [DB-1:0] fd, input logic bf,
                                      input logic [FB-1:0] bk, input logic [DB-1:0] bd,
                                      input logic [RADIUS_BITS-1:0] rad);
    logic          have_fwd;
    logic          take_b;
    logic [DB-1:0] rad_w;
    pick_t         r;
    rad_w    = DB'(rad);
    have_fwd = ff && (fd <= rad_w);
    take_b   = bf && (have_fwd ? (bd < fd) : (bd <= rad_w));
    r.moved  = take_b || (have_fwd && (fd != '0));
    r.tgt    = take_b ? bk : fk;
    r.gap    = take_b ? bd : fd;
    return r;
  endfunction

  // Captured transaction, keys in offset-binary form
  logic [1:0]             op_q;
  logic [FB-1:0]          tgt_key_q;
  logic [FB-1:0]          start_key_q;
  logic [DUR_BITS-1:0]    dur_q;
  logic [RADIUS_BITS-1:0] radius_q;

  logic [FB-1:0] mem [MAX_TARGETS];
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] idx_q;
  logic             full;

  // Scan pipeline
  logic          v1_q, v2_q;
  logic [FB-1:0] rdata_q;
  logic [FB-1:0] tb_q;
  logic          gel_q, get_q;
  logic [DB-1:0] el, et_q;

  // Trackers: least key at-or-after the edge, greatest key before it
  logic          ffl_q, bfl_q, fft_q, bft_q;
  logic [FB-1:0] fkl_q, bkl_q, fkt_q, bkt_q;
  logic [DB-1:0] fdl_q, bdl_q, fdt_q, bdt_q;
  pick_t         pl_q, pt_q;

  logic [DB-1:0] tdiff;
  logic [FB-1:0] tstart;
  logic          lsel;
  dses_out_t     res_q, out_q;

  assign full = (count_q == CNT_W'(MAX_TARGETS));
  assign el   = {1'b0, start_key_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q        <= in_data_i.opcode;
      tgt_key_q   <= in_data_i.target_frame ^ KEY_SIGN;
      start_key_q <= in_data_i.raw_start ^ KEY_SIGN;
      dur_q       <= in_data_i.duration;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load_exec && !full) begin
      count_q <= count_q + CNT_W'(1);
    end else if (cmd_i.clear_tab && (op_q == OP_CLEAR)) begin
      count_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_exec && !full) begin
      mem[count_q[IDX_W-1:0]] <= tgt_key_q;
    end
    if (cmd_i.scan_issue) begin
      rdata_q <= mem[idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      if (cmd_i.setup) begin
        idx_q <= '0;
      end else if (cmd_i.scan_issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      v1_q <= cmd_i.scan_issue;
      v2_q <= v1_q;
    end
  end

  // Classify each key against both edges
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      et_q <= el + DB'(dur_q);
    end
    if (v1_q) begin
      tb_q  <= rdata_q;
      gel_q <= ({1'b0, rdata_q} >= el);
      get_q <= ({1'b0, rdata_q} >= et_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ffl_q <= 1'b0;
      bfl_q <= 1'b0;
      fft_q <= 1'b0;
      bft_q <= 1'b0;
    end else if (cmd_i.setup) begin
      ffl_q <= 1'b0;
      bfl_q <= 1'b0;
      fft_q <= 1'b0;
      bft_q <= 1'b0;
    end else if (v2_q) begin
      if (gel_q) begin
        if (!ffl_q || (tb_q < fkl_q)) ffl_q <= 1'b1;
      end else if (!bfl_q || (tb_q > bkl_q)) begin
        bfl_q <= 1'b1;
      end
      if (get_q) begin
        if (!fft_q || (tb_q < fkt_q)) fft_q <= 1'b1;
      end else if (!bft_q || (tb_q > bkt_q)) begin
        bft_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && !cmd_i.setup) begin
      if (gel_q) begin
        if (!ffl_q || (tb_q < fkl_q)) fkl_q <= tb_q;
      end else if (!bfl_q || (tb_q > bkl_q)) begin
        bkl_q <= tb_q;
      end
      if (get_q) begin
        if (!fft_q || (tb_q < fkt_q)) fkt_q <= tb_q;
      end else if (!bft_q || (tb_q > bkt_q)) begin
        bkt_q <= tb_q;
      end
    end
  end

  // Distances, per-edge decision, then the final pick
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin1) begin
      fdl_q <= {1'b0, fkl_q} - el;
      bdl_q <= el - {1'b0, bkl_q};
      fdt_q <= {1'b0, fkt_q} - et_q;
      bdt_q <= et_q - {1'b0, bkt_q};
    end
    if (cmd_i.fin2) begin
      pl_q <= pick_edge(ffl_q, fkl_q, fdl_q, bfl_q, bkl_q, bdl_q, radius_q);
      pt_q <= pick_edge(fft_q, fkt_q, fdt_q, bft_q, bkt_q, bdt_q, radius_q);
    end
  end

  assign tdiff  = {1'b0, pt_q.tgt} - DB'(dur_q);
  // Clamp a trailing-edge start below frame 0
  assign tstart = (!tdiff[DB-1] && tdiff[FB-1]) ? tdiff[FB-1:0] : KEY_SIGN;
  assign lsel   = pl_q.moved && (!pt_q.moved || (pl_q.gap <= pt_q.gap));

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_zero) begin
      res_q <= '0;
    end else if (cmd_i.load_exec) begin
      res_q.start_frame <= '0;
      res_q.edge_used   <= EDGE_NONE;
      res_q.status      <= full ? STATUS_FULL : STATUS_OK;
    end else if (cmd_i.res_raw) begin
      res_q.start_frame <= start_key_q ^ KEY_SIGN;
      res_q.edge_used   <= EDGE_NONE;
      res_q.status      <= STATUS_OK;
    end else if (cmd_i.fin3) begin
      res_q.status <= STATUS_OK;
      if (lsel) begin
        res_q.start_frame <= pl_q.tgt ^ KEY_SIGN;
        res_q.edge_used   <= EDGE_LEAD;
      end else if (pt_q.moved) begin
        res_q.start_frame <= tstart ^ KEY_SIGN;
        res_q.edge_used   <= EDGE_TRAIL;
      end else begin
        res_q.start_frame <= start_key_q ^ KEY_SIGN;
        res_q.edge_used   <= EDGE_NONE;
      end
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign stat_o.snap_off  = (radius_q == '0) || (dur_q == '0) || (count_q == '0);
  assign stat_o.scan_done = (idx_q == count_q);
  assign stat_o.pipe_busy = v1_q || v2_q;
  assign out_data_o       = out_q;

  `DSES_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(MAX_TARGETS))
  `DSES_ASSERT_IMPL(a_issue_in_range, clk_i, rst_ni, cmd_i.scan_issue, idx_q < count_q)

endmodule

/* src/dragged_span_edge_snap_core.sv */
// ----------------------------------------------------------------------------
// dragged_span_edge_snap_core
// Snaps the edges of a dragged span to the nearest target frame in a table.
// ----------------------------------------------------------------------------
// A transaction is a load (append one target), a clear (empty the table) or
// a snap query; every transaction returns exactly one result. Load and clear
// results enter the output register once it is free. A query scans the whole
// table once through a single read port, one target per cycle, and checks
// each target against both edges at the same time; it then drains the
// pipeline and forms distances, per-edge picks and the final pick. A query
// with snapping off (radius 0, duration 0 or an empty table) returns the raw
// start without a scan. One transaction is worked on at a time; the next one
// is taken as soon as the previous result sits in the output register, even
// if the consumer has not yet taken it. The radius register is written
// through cfg_we_i/cfg_wdata_i and should change only while the block is
// idle. The table holds up to MAX_TARGETS frames; loads into a full table
// are dropped and flagged in the status field.
// ----------------------------------------------------------------------------
module dragged_span_edge_snap_core import dses_pkg::*; #(
  parameter int MAX_TARGETS = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dses_in_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dses_out_t              out_data_o,
  input  logic                   cfg_we_i,
  input  logic [RADIUS_BITS-1:0] cfg_wdata_i
);

  dses_cmd_t  cmd;
  dses_stat_t stat;

  // Sequence each transaction and hold the output slot
  dses_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Table, scan pipeline and result registers
  dses_dpath #(
    .MAX_TARGETS (MAX_TARGETS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

/* sim/dragged_span_edge_snap_core_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dragged_span_edge_snap_core_checker
// Watches both channels and the radius port of the edge snapper, predicts
// each result from a private copy of the target table and compares in order.
// ----------------------------------------------------------------------------
module dragged_span_edge_snap_core_checker
  import dses_pkg::*;
#(
  parameter int MAX_TARGETS = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  dses_in_t               in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  dses_out_t              out_data_i,
  input  logic                   cfg_we_i,
  input  logic [RADIUS_BITS-1:0] cfg_wdata_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     results_o,
  output int                     lead_snaps_o,
  output int                     trail_snaps_o,
  output int                     dropped_loads_o
);

  // Targets are held as keys (sign bit flipped) so unsigned order is frame order.
  logic [FRAME_BITS-1:0]  target_keys [MAX_TARGETS];
  int unsigned            target_total;
  logic [RADIUS_BITS-1:0] radius;
  dses_out_t              predicted_snaps [$];

  int fails = 0;
  int pending = 0;
  int results = 0;
  int lead_snaps = 0;
  int trail_snaps = 0;
  int dropped_loads = 0;

  assign fail_count_o    = fails;
  assign pending_o       = pending;
  assign results_o       = results;
  assign lead_snaps_o    = lead_snaps;
  assign trail_snaps_o   = trail_snaps;
  assign dropped_loads_o = dropped_loads;

  task automatic report_mismatch(input string what, input logic [FRAME_BITS-1:0] want,
                                 input logic [FRAME_BITS-1:0] got);
    if (fails < 30) begin
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    end
    fails++;
  endtask

  // Pick the target for one edge at pos_key + offset; returns 1 if the edge moves.
  function automatic logic nearest_target(input logic [FRAME_BITS-1:0] pos_key,
                                          input logic [DUR_BITS-1:0] offset,
                                          output logic [FRAME_BITS-1:0] tgt_key,
                                          output logic [DIST_BITS-1:0] move_len);
    logic                  fwd_found, back_found, fwd_ok;
    logic [FRAME_BITS-1:0] fwd_key, back_key, cand, rel;
    logic [DIST_BITS-1:0]  fwd_gap, back_gap, gap, limit;
    fwd_found  = 1'b0;
    back_found = 1'b0;
    fwd_key    = '0;
    back_key   = '0;
    fwd_gap    = '0;
    back_gap   = '0;
    tgt_key    = '0;
    move_len   = '0;
    limit      = DIST_BITS'(radius);
    for (int i = 0; i < target_total; i++) begin
      cand = target_keys[i];
      rel  = cand - pos_key;
      if (cand >= pos_key && rel >= FRAME_BITS'(offset)) begin
        gap = DIST_BITS'(rel) - DIST_BITS'(offset);
        if (!fwd_found || gap < fwd_gap) begin
          fwd_found = 1'b1;
          fwd_gap   = gap;
          fwd_key   = cand;
        end
      end else begin
        if (cand >= pos_key) gap = DIST_BITS'(offset) - DIST_BITS'(rel);
        else gap = DIST_BITS'(pos_key - cand) + DIST_BITS'(offset);
        if (!back_found || gap < back_gap) begin
          back_found = 1'b1;
          back_gap   = gap;
          back_key   = cand;
        end
      end
    end
    fwd_ok = fwd_found && fwd_gap <= limit;
    if (fwd_ok) begin
      limit    = fwd_gap;
      tgt_key  = fwd_key;
      move_len = fwd_gap;
    end
    // The earlier target only wins when strictly closer, or when nothing ahead fits.
    if (back_found && (back_gap < limit || (back_gap == limit && !fwd_ok))) begin
      tgt_key  = back_key;
      move_len = back_gap;
      return 1'b1;
    end
    return fwd_ok && fwd_gap != 0;
  endfunction

  // Apply one transaction to the table copy and return the result it produces.
  function automatic dses_out_t snap_span(input dses_in_t item);
    dses_out_t             res;
    logic [FRAME_BITS-1:0] pos, start_key, lead_key, trail_key, trail_start;
    logic [DIST_BITS-1:0]  lead_len, trail_len;
    logic                  lead_moved, trail_moved;
    res = '0;
    case (item.opcode)
      OP_LOAD: begin
        if (target_total < MAX_TARGETS) begin
          target_keys[target_total] = item.target_frame ^ KEY_SIGN;
          target_total++;
        end else begin
          res.status = STATUS_FULL;
        end
      end
      OP_CLEAR: begin
        target_total = 0;
      end
      OP_QUERY: begin
        pos       = item.raw_start ^ KEY_SIGN;
        start_key = pos;
        if (radius != 0 && item.duration != 0 && target_total != 0) begin
          lead_moved  = nearest_target(pos, '0, lead_key, lead_len);
          trail_moved = nearest_target(pos, item.duration, trail_key, trail_len);
          // Clamp a start derived from the trailing edge at frame 0.
          if (DIST_BITS'(trail_key) >= DIST_BITS'(KEY_SIGN) + DIST_BITS'(item.duration)) begin
            trail_start = trail_key - FRAME_BITS'(item.duration);
          end else begin
            trail_start = KEY_SIGN;
          end
          if (lead_moved && (!trail_moved || lead_len <= trail_len)) begin
            start_key     = lead_key;
            res.edge_used = EDGE_LEAD;
          end else if (trail_moved) begin
            start_key     = trail_start;
            res.edge_used = EDGE_TRAIL;
          end
        end
        res.start_frame = start_key ^ KEY_SIGN;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    dses_out_t want;
    if (!rst_ni) begin
      target_total = 0;
      radius       = '0;
      predicted_snaps.delete();
    end else begin
      if (cfg_we_i) radius = cfg_wdata_i;
      // Compare before predicting, so a result never meets its own prediction.
      if (out_valid_i && out_ready_i) begin
        results++;
        if (predicted_snaps.size() == 0) begin
          report_mismatch("result with nothing expected", '0, out_data_i.start_frame);
        end else begin
          want = predicted_snaps.pop_front();
          if (out_data_i.start_frame !== want.start_frame)
            report_mismatch("start_frame", want.start_frame, out_data_i.start_frame);
          if (out_data_i.edge_used !== want.edge_used)
            report_mismatch("edge_used", FRAME_BITS'(want.edge_used),
                            FRAME_BITS'(out_data_i.edge_used));
          if (out_data_i.status !== want.status)
            report_mismatch("status", FRAME_BITS'(want.status), FRAME_BITS'(out_data_i.status));
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = snap_span(in_data_i);
        if (want.edge_used == EDGE_LEAD) lead_snaps++;
        if (want.edge_used == EDGE_TRAIL) trail_snaps++;
        if (want.status == STATUS_FULL) dropped_loads++;
        predicted_snaps.push_back(want);
      end
    end
    pending = predicted_snaps.size();
  end

endmodule

/* sim/dragged_span_edge_snap_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dragged_span_edge_snap_core_test
// Drives directed and random load, clear and snap transactions into the edge
// snapper under bursty input and a stalling consumer, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module dragged_span_edge_snap_core_test;
  import dses_pkg::*;

  localparam int MAX_TARGETS  = 256;
  localparam int RANDOM_ITEMS = 750;
  localparam int QUIET_LIMIT  = 4000;  // worst query plus long hold, several times over
  localparam int LONG_HOLD    = 600;
  localparam int HOLD_AFTER   = 300;
  localparam int FILL_PHASE   = 3;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [FRAME_BITS-1:0] FRAME_MAX = {1'b0, {(FRAME_BITS-1){1'b1}}};
  localparam logic signed [FRAME_BITS-1:0] FRAME_MIN = {1'b1, {(FRAME_BITS-1){1'b0}}};
  localparam logic [DUR_BITS-1:0]          DUR_MAX   = '1;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  dses_in_t               in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  dses_out_t              out_data_o;
  logic                   cfg_we_i    = 1'b0;
  logic [RADIUS_BITS-1:0] cfg_wdata_i = '0;

  int fail_count, pending, results, lead_snaps, trail_snaps, dropped_loads;

  // Stimulus bookkeeping.
  int burst_left = 0;
  int delivered  = 0;
  int n_settings = 0;
  logic signed [FRAME_BITS-1:0] loaded_frames [$];

  always #10 clk_i = ~clk_i;

  dragged_span_edge_snap_core #(
    .MAX_TARGETS (MAX_TARGETS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  dragged_span_edge_snap_core_checker #(
    .MAX_TARGETS (MAX_TARGETS)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_i      (out_data_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .results_o       (results),
    .lead_snaps_o    (lead_snaps),
    .trail_snaps_o   (trail_snaps),
    .dropped_loads_o (dropped_loads)
  );

  // --------------------------------------------------------------------------
  // Random value helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [FRAME_BITS-1:0] rand_frame();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[FRAME_BITS-1:0];
  endfunction

  // Signed offset in [-span, span].
  function automatic logic signed [FRAME_BITS-1:0] rand_offset(input int span);
    return FRAME_BITS'(longint'($urandom_range(0, 2 * span)) - longint'(span));
  endfunction

  // Mostly short spans, with zero, the maximum and full-width values mixed in.
  function automatic logic [DUR_BITS-1:0] rand_duration(input int span);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return DUR_MAX;
      2:       return r[DUR_BITS-1:0];
      default: return DUR_BITS'($urandom_range(1, span * 4));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between bursts
  // --------------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so back-to-back transactions never drop valid in between.
  task automatic send_item(input dses_in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      // Now and then a long burst, so some stretches run with no idling at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_data_i  = item;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Unused fields of each transaction carry random bits.
  task automatic send_load(input logic signed [FRAME_BITS-1:0] frame);
    send_item({OP_LOAD, frame, rand_frame(), rand_duration(1000)});
    loaded_frames.push_back(frame);
  endtask

  task automatic send_clear();
    send_item({OP_CLEAR, rand_frame(), rand_frame(), rand_duration(1000)});
    loaded_frames.delete();
  endtask

  task automatic send_query(input logic signed [FRAME_BITS-1:0] raw,
                            input logic [DUR_BITS-1:0] dur);
    send_item({OP_QUERY, rand_frame(), raw, dur});
  endtask

  // Drain the block before touching the radius; every transaction returns a
  // result, so no expected result outstanding means the block is idle.
  task automatic set_radius(input logic [RADIUS_BITS-1:0] value);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: a random stall style for each stretch, plus one long
  // hold-off that backs the block up until it stalls its input
  // --------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int stretch;
    int tick;
    bit held;
    held = 1'b0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(10, 80);
      repeat (stretch) begin
        @(negedge clk_i);
        tick++;
        if (!held && delivered >= HOLD_AFTER) begin
          held        = 1'b1;
          out_ready_i = 1'b0;
          repeat (LONG_HOLD) @(negedge clk_i);
        end
        case (mode)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = ($urandom_range(0, 3) != 0);
          2:       out_ready_i = ($urandom_range(0, 4) == 0);
          default: out_ready_i = (tick % 5) != 0;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no transaction moves for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) delivered++;
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [RADIUS_BITS-1:0]       radius;
    logic signed [FRAME_BITS-1:0] base, anchor, raw;
    logic [DUR_BITS-1:0]          dur;
    int spread, n_loads, n_queries, pick, phase, random_sent;

    phase       = 0;
    random_sent = 0;

    // Hold reset, then release it away from the rising edge.
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. Radius is still at its reset value of 0 here.
    send_query(48'sd123, 47'd5);                  // empty table, snapping off
    send_clear();
    send_item({OP_UNUSED, {FRAME_BITS{1'b1}}, {FRAME_BITS{1'b1}}, DUR_MAX});  // ignored
    send_load(FRAME_MAX);
    send_load(FRAME_MIN);
    send_load('0);
    send_load(48'sd100);
    send_load(-48'sd100);
    send_query(48'sd95, 47'd10);                  // radius 0 keeps the raw start

    set_radius(16'd60);
    send_query(48'sd95, '0);                      // zero duration keeps the raw start
    send_query(48'sd95, 47'd3);                   // trailing edge moves less
    send_query(48'sd50, 47'd1000);                // equal distance both sides: later wins
    send_query(48'sd4, 47'd1000);                 // only an earlier target in reach
    send_query(-48'sd105, 47'd100);               // equal moves on both edges: start wins
    send_query(-48'sd30, 47'd20);                 // trailing snap clamped at frame 0
    send_query(FRAME_MAX - 48'sd5, DUR_MAX);      // trailing edge beyond the frame range
    send_query(FRAME_MAX, DUR_MAX);               // start already on a target
    send_query(FRAME_MIN + 48'sd3, 47'd1);        // snap down to the lowest frame
    send_query(FRAME_MIN, DUR_MAX);               // trailing edge lands just below 0

    // Random part: each phase programs a radius, builds a small target set
    // around a base frame and fires queries aimed at those targets.
    while (random_sent < RANDOM_ITEMS) begin
      case (phase % 6)
        0:       radius = 16'd1;
        1:       radius = '1;
        2:       radius = '0;
        3:       radius = RADIUS_BITS'($urandom_range(2, 64));
        4:       radius = RADIUS_BITS'($urandom_range(65, 65534));
        default: radius = RADIUS_BITS'($urandom_range(1, 1000));
      endcase
      set_radius(radius);
      spread = (radius == 0) ? 50 : int'(radius) * $urandom_range(1, 3);

      // Place the cluster near zero, the extremes, or anywhere.
      case ($urandom_range(0, 4))
        0:       base = '0;
        1:       base = FRAME_MAX;
        2:       base = FRAME_MIN;
        default: base = rand_frame();
      endcase

      if ($urandom_range(0, 9) != 0) begin
        send_clear();
        random_sent++;
      end

      // One phase fills the table past capacity; the rest stay small.
      if (phase == FILL_PHASE) n_loads = MAX_TARGETS + 4;
      else if ($urandom_range(0, 9) == 0) n_loads = 0;
      else n_loads = $urandom_range(1, 12);
      repeat (n_loads) begin
        send_load(base + rand_offset(spread * 4));
        random_sent++;
      end

      n_queries = (phase == FILL_PHASE) ? 8 : $urandom_range(8, 30);
      repeat (n_queries) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          send_item({OP_UNUSED, rand_frame(), rand_frame(), rand_duration(spread)});
        end else if (pick == 1) begin
          send_load(rand_frame());
          random_sent++;
        end else if (pick == 2 && $urandom_range(0, 2) == 0) begin
          send_clear();
          random_sent++;
        end else begin
          dur = rand_duration(spread);
          if (loaded_frames.size() == 0) begin
            raw = base + rand_offset(spread * 4);
          end else begin
            anchor = loaded_frames[$urandom_range(0, loaded_frames.size() - 1)];
            case ($urandom_range(0, 9))
              0, 1, 2, 3: raw = anchor + rand_offset(spread * 2);
              4, 5, 6, 7: raw = anchor - {1'b0, dur} + rand_offset(spread * 2);
              8:          raw = base + rand_offset(spread * 8);
              default: begin
                raw = rand_frame();
                dur = rand_duration(spread) ^ DUR_BITS'({$urandom, $urandom});
              end
            endcase
          end
          send_query(raw, dur);
          random_sent++;
        end
      end
      phase++;
    end

    // Drop valid, drain, then give the block a full scan to show stray results.
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (MAX_TARGETS + 16) @(negedge clk_i);

    $display("Checked %0d results: %0d leading-edge snaps, %0d trailing-edge snaps,",
             results, lead_snaps, trail_snaps);
    $display("%0d dropped loads; radius programmed %0d times over %0d random target sets",
             dropped_loads, n_settings, phase);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
